// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock, switched off while reset is low
`define PIC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block's own clock and reset
`define PIC_ASSERT(lbl, prop, msg) `PIC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== src/pic_pkg.sv =====
// Types, widths, register codes and helpers for the point-in-capsule test
`default_nettype none

package pic_pkg;

    localparam int COORD_W   = 16;
    localparam int COMP_W    = 16;
    localparam int AXIS_FRAC = 14;
    localparam int NUM_AXES  = 3;
    localparam int R_W       = 15;
    localparam int CFG_W     = 3 * COMP_W;
    localparam int CFG_IDX_W = 3;

    localparam int DELTA_W   = ((COORD_W > COMP_W) ? COORD_W : COMP_W) + 1;
    localparam int PROD_W    = DELTA_W + COMP_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int PROJ_W    = SUM_W - AXIS_FRAC;
    localparam int OFFP_W    = COMP_W + R_W;
    localparam int OFF_W     = OFFP_W - AXIS_FRAC;
    localparam int V_W       = ((DELTA_W > OFF_W) ? DELTA_W : OFF_W) + 1;
    localparam int SQ_W      = 2 * R_W;
    localparam int XZ_SUM_W  = SQ_W + 1;
    localparam int V_SUM_W   = SQ_W + 2;

    localparam int NUM_STAGES = 6;

    localparam logic [CFG_W-1:0] AXIS_X_RST = CFG_W'(1 << AXIS_FRAC);
    localparam logic [CFG_W-1:0] AXIS_Y_RST = CFG_W'(1 << AXIS_FRAC) << COMP_W;
    localparam logic [CFG_W-1:0] AXIS_Z_RST = CFG_W'(1 << AXIS_FRAC) << (2 * COMP_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_AXIS_X   = 3'd1,
        CFG_AXIS_Y   = 3'd2,
        CFG_AXIS_Z   = 3'd3,
        CFG_RADIUS   = 3'd4,
        CFG_HALF_LEN = 3'd5
    } t_cfg_idx;

    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef t_delta t_delta_vec [NUM_AXES];

    // Load enables of the two projection stages
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } t_proj_adv;

    // Early-out decisions carried down the back end of the pipe
    typedef struct packed {
        logic xz_over;
        logic body;
        logic v_over;
    } t_flags;

    function automatic logic signed [COMP_W-1:0] comp_of(
        input logic [CFG_W-1:0] vec,
        input int unsigned      idx
    );
        return vec[idx*COMP_W +: COMP_W];
    endfunction

endpackage

`default_nettype wire

// ===== src/pic_proj.sv =====
// Two-stage projection of a delta vector onto one Q1.14 axis
`default_nettype none

module pic_proj (
    input  logic                                i_clk,
    input  pic_pkg::t_proj_adv                  i_adv,
    input  pic_pkg::t_delta_vec                 i_delta,
    input  logic [pic_pkg::CFG_W-1:0]           i_axis,
    output logic signed [pic_pkg::PROJ_W-1:0]   o_proj
);

    logic signed [pic_pkg::PROD_W-1:0] r_prod [pic_pkg::NUM_AXES];
    logic signed [pic_pkg::PROD_W-1:0] w_a    [pic_pkg::NUM_AXES];
    logic signed [pic_pkg::PROD_W-1:0] w_b    [pic_pkg::NUM_AXES];
    logic signed [pic_pkg::SUM_W-1:0]  w_sum;
    logic signed [pic_pkg::PROJ_W-1:0] r_proj;

    always_comb begin
        for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
            w_a[i] = pic_pkg::PROD_W'(i_delta[i]);
            w_b[i] = pic_pkg::PROD_W'(pic_pkg::comp_of(i_axis, i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.prod_en) begin
            for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
                r_prod[i] <= w_a[i] * w_b[i];
            end
        end
    end

    assign w_sum = pic_pkg::SUM_W'(r_prod[0]) + pic_pkg::SUM_W'(r_prod[1])
                 + pic_pkg::SUM_W'(r_prod[2]);

    // Dropping the fraction bits of the sum is the floor shift
    always_ff @(posedge i_clk) begin
        if (i_adv.sum_en) begin
            r_proj <= w_sum[pic_pkg::SUM_W-1:pic_pkg::AXIS_FRAC];
        end
    end

    assign o_proj = r_proj;

endmodule

`default_nettype wire

// ===== src/point_in_capsule_test_unit.sv =====
// Top level of the point-in-capsule containment test
//
// Takes one signed Q8.8 point per cycle unless stalled and answers whether
// it lies inside the capsule held in the configuration registers (sphere
// when the half length is zero). The datapath is a six-stage pipeline:
// centre offset, axis products, projection sums, radius and end-cap checks,
// squares, and the final compare into the output register. Sustained rate
// is one point per cycle while the output is not stalled. Each stage holds
// its request only while the stage after it is full, so bubbles close up
// under a stall and input keeps being taken until every stage is occupied.
// The configuration port is always ready; write it only while no point is
// in flight.
`default_nettype none

module point_in_capsule_test_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [pic_pkg::COORD_W-1:0]      i_point_x,
    input  logic signed [pic_pkg::COORD_W-1:0]      i_point_y,
    input  logic signed [pic_pkg::COORD_W-1:0]      i_point_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_inside_res,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pic_pkg::CFG_W-1:0]               i_cfg_data
);

    // Configuration
    logic [pic_pkg::CFG_W-1:0] r_center;
    logic [pic_pkg::CFG_W-1:0] r_axis_x;
    logic [pic_pkg::CFG_W-1:0] r_axis_y;
    logic [pic_pkg::CFG_W-1:0] r_axis_z;
    logic [pic_pkg::R_W-1:0]   r_radius;
    logic [pic_pkg::R_W-1:0]   r_half_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= '0;
            r_axis_x   <= pic_pkg::AXIS_X_RST;
            r_axis_y   <= pic_pkg::AXIS_Y_RST;
            r_axis_z   <= pic_pkg::AXIS_Z_RST;
            r_radius   <= '0;
            r_half_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pic_pkg::CFG_CENTER:   r_center   <= i_cfg_data;
                pic_pkg::CFG_AXIS_X:   r_axis_x   <= i_cfg_data;
                pic_pkg::CFG_AXIS_Y:   r_axis_y   <= i_cfg_data;
                pic_pkg::CFG_AXIS_Z:   r_axis_z   <= i_cfg_data;
                pic_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[pic_pkg::R_W-1:0];
                pic_pkg::CFG_HALF_LEN: r_half_len <= i_cfg_data[pic_pkg::R_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic [pic_pkg::NUM_STAGES:0]   w_rdy;
    logic [pic_pkg::NUM_STAGES-1:0] r_vld;
    logic [pic_pkg::NUM_STAGES-1:0] w_vld_in;

    always_comb begin
        w_rdy[pic_pkg::NUM_STAGES] = !i_stall;
        for (int k = pic_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vld_in = {r_vld[pic_pkg::NUM_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < pic_pkg::NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[pic_pkg::NUM_STAGES-1];

    // Stage 0: offset from the centre
    pic_pkg::t_delta_vec r_s0_d;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_d[0] <= pic_pkg::DELTA_W'(i_point_x)
                       - pic_pkg::DELTA_W'(pic_pkg::comp_of(r_center, 0));
            r_s0_d[1] <= pic_pkg::DELTA_W'(i_point_y)
                       - pic_pkg::DELTA_W'(pic_pkg::comp_of(r_center, 1));
            r_s0_d[2] <= pic_pkg::DELTA_W'(i_point_z)
                       - pic_pkg::DELTA_W'(pic_pkg::comp_of(r_center, 2));
        end
    end

    // Stages 1 and 2: projections onto the three axes
    pic_pkg::t_proj_adv                w_proj_adv;
    logic signed [pic_pkg::PROJ_W-1:0] w_proj_x;
    logic signed [pic_pkg::PROJ_W-1:0] w_proj_y;
    logic signed [pic_pkg::PROJ_W-1:0] w_proj_z;

    assign w_proj_adv.prod_en = w_rdy[1];
    assign w_proj_adv.sum_en  = w_rdy[2];

    pic_proj u_proj_x (
        .i_clk   (i_clk),
        .i_adv   (w_proj_adv),
        .i_delta (r_s0_d),
        .i_axis  (r_axis_x),
        .o_proj  (w_proj_x)
    );

    pic_proj u_proj_y (
        .i_clk   (i_clk),
        .i_adv   (w_proj_adv),
        .i_delta (r_s0_d),
        .i_axis  (r_axis_y),
        .o_proj  (w_proj_y)
    );

    pic_proj u_proj_z (
        .i_clk   (i_clk),
        .i_adv   (w_proj_adv),
        .i_delta (r_s0_d),
        .i_axis  (r_axis_z),
        .o_proj  (w_proj_z)
    );

    // End-cap centre offset runs alongside; it is zero for the sphere case
    pic_pkg::t_delta_vec               r_s1_d;
    pic_pkg::t_delta_vec               r_s2_d;
    logic signed [pic_pkg::OFFP_W-1:0] r_s1_offp [pic_pkg::NUM_AXES];
    logic signed [pic_pkg::OFF_W-1:0]  r_s2_off  [pic_pkg::NUM_AXES];
    logic signed [pic_pkg::OFFP_W-1:0] w_hl_s;

    assign w_hl_s = pic_pkg::OFFP_W'($signed({1'b0, r_half_len}));

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_d <= r_s0_d;
            for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
                r_s1_offp[i] <= pic_pkg::OFFP_W'(pic_pkg::comp_of(r_axis_y, i)) * w_hl_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_d <= r_s1_d;
            for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
                r_s2_off[i] <= r_s1_offp[i][pic_pkg::OFFP_W-1:pic_pkg::AXIS_FRAC];
            end
        end
    end

    // Stage 3: magnitudes against the radius, body test, cap vector
    logic [pic_pkg::PROJ_W-1:0]     w_pxa;
    logic [pic_pkg::PROJ_W-1:0]     w_pya;
    logic [pic_pkg::PROJ_W-1:0]     w_pza;
    logic                           w_py_pos;
    logic signed [pic_pkg::V_W-1:0] w_v  [pic_pkg::NUM_AXES];
    logic [pic_pkg::V_W-1:0]        w_va [pic_pkg::NUM_AXES];
    pic_pkg::t_flags                w_flags;

    always_comb begin
        w_pxa = w_proj_x[pic_pkg::PROJ_W-1] ? pic_pkg::PROJ_W'(-w_proj_x)
                                            : pic_pkg::PROJ_W'(w_proj_x);
        w_pya = w_proj_y[pic_pkg::PROJ_W-1] ? pic_pkg::PROJ_W'(-w_proj_y)
                                            : pic_pkg::PROJ_W'(w_proj_y);
        w_pza = w_proj_z[pic_pkg::PROJ_W-1] ? pic_pkg::PROJ_W'(-w_proj_z)
                                            : pic_pkg::PROJ_W'(w_proj_z);
        w_py_pos = !w_proj_y[pic_pkg::PROJ_W-1] && (w_proj_y != '0);

        w_flags.xz_over = (w_pxa > pic_pkg::PROJ_W'(r_radius))
                       || (w_pza > pic_pkg::PROJ_W'(r_radius));
        w_flags.body    = w_pya < pic_pkg::PROJ_W'(r_half_len);
        w_flags.v_over  = 1'b0;

        // Pick the cap on the side the point lies
        for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
            w_v[i] = w_py_pos ? pic_pkg::V_W'(r_s2_d[i]) - pic_pkg::V_W'(r_s2_off[i])
                              : pic_pkg::V_W'(r_s2_d[i]) + pic_pkg::V_W'(r_s2_off[i]);
            w_va[i] = w_v[i][pic_pkg::V_W-1] ? pic_pkg::V_W'(-w_v[i])
                                             : pic_pkg::V_W'(w_v[i]);
            if (w_va[i] > pic_pkg::V_W'(r_radius)) begin
                w_flags.v_over = 1'b1;
            end
        end
    end

    pic_pkg::t_flags          r_s3_flags;
    logic [pic_pkg::R_W-1:0]  r_s3_px;
    logic [pic_pkg::R_W-1:0]  r_s3_pz;
    logic [pic_pkg::R_W-1:0]  r_s3_va [pic_pkg::NUM_AXES];

    // Values above the radius are flagged, so the low bits suffice
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_flags <= w_flags;
            r_s3_px    <= w_pxa[pic_pkg::R_W-1:0];
            r_s3_pz    <= w_pza[pic_pkg::R_W-1:0];
            for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
                r_s3_va[i] <= w_va[i][pic_pkg::R_W-1:0];
            end
        end
    end

    // Stage 4: squares
    pic_pkg::t_flags          r_s4_flags;
    logic [pic_pkg::SQ_W-1:0] r_s4_px_sq;
    logic [pic_pkg::SQ_W-1:0] r_s4_pz_sq;
    logic [pic_pkg::SQ_W-1:0] r_s4_v_sq [pic_pkg::NUM_AXES];
    logic [pic_pkg::SQ_W-1:0] r_s4_r_sq;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_flags <= r_s3_flags;
            r_s4_px_sq <= pic_pkg::SQ_W'(r_s3_px) * pic_pkg::SQ_W'(r_s3_px);
            r_s4_pz_sq <= pic_pkg::SQ_W'(r_s3_pz) * pic_pkg::SQ_W'(r_s3_pz);
            for (int i = 0; i < pic_pkg::NUM_AXES; i++) begin
                r_s4_v_sq[i] <= pic_pkg::SQ_W'(r_s3_va[i]) * pic_pkg::SQ_W'(r_s3_va[i]);
            end
            r_s4_r_sq <= pic_pkg::SQ_W'(r_radius) * pic_pkg::SQ_W'(r_radius);
        end
    end

    // Stage 5: final compares into the output register
    logic [pic_pkg::XZ_SUM_W-1:0] w_xz_sum;
    logic [pic_pkg::V_SUM_W-1:0]  w_v_sum;
    logic                         w_xz_ok;
    logic                         w_sph_ok;
    logic                         w_sphere;
    logic                         r_s5_inside;

    always_comb begin
        w_xz_sum = pic_pkg::XZ_SUM_W'(r_s4_px_sq) + pic_pkg::XZ_SUM_W'(r_s4_pz_sq);
        w_v_sum  = pic_pkg::V_SUM_W'(r_s4_v_sq[0]) + pic_pkg::V_SUM_W'(r_s4_v_sq[1])
                 + pic_pkg::V_SUM_W'(r_s4_v_sq[2]);
        w_xz_ok  = !r_s4_flags.xz_over && (w_xz_sum <= pic_pkg::XZ_SUM_W'(r_s4_r_sq));
        w_sph_ok = !r_s4_flags.v_over && (w_v_sum <= pic_pkg::V_SUM_W'(r_s4_r_sq));
        w_sphere = (r_half_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s5_inside <= (w_sphere || w_xz_ok) && (r_s4_flags.body || w_sph_ok);
        end
    end

    assign o_inside_res = r_s5_inside;

endmodule

`default_nettype wire

// ===== src/pic_checker.sv =====
// Port-level checker for the point-in-capsule test, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module pic_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_inside_res
);

    // Input is held back only when every stage is full and the output waits
    `PIC_ASSERT(a_stall_only_full, o_stall |-> (o_valid && i_stall), "stall while not full")

    // A taken request passes through every stage and comes out when nothing stalls
    `PIC_ASSERT(a_latency, (i_valid && !o_stall) ##1 (!i_stall) [*5] |=> o_valid, "late result")

    // A stalled result holds
    `PIC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_inside_res), "output moved")

endmodule

bind point_in_capsule_test_unit pic_checker u_pic_checker (.*);

`default_nettype wire
